// File: hdl/locd_pkg.sv
// package: types, constants and state codes of the lock order cycle detector
`timescale 1ns / 1ps
package locd_pkg;

    localparam int LOCKS       = 32;
    localparam int STACK_DEPTH = 16;
    localparam int LK_W        = $clog2(LOCKS);
    localparam int NXT_W       = $clog2(LOCKS) + 1;
    localparam int HS_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH) + 1;
    localparam int SP_W        = $clog2(LOCKS);
    localparam int SS_W        = LK_W + NXT_W;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CYCLE     = 3'd1;
    localparam logic [2:0] ST_REL_EMPTY = 3'd2;
    localparam logic [2:0] ST_REL_NOTOP = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_HALTED    = 3'd5;

    typedef struct packed {
        logic       command;
        logic [4:0] lock_number;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic       new_edge;
        logic [4:0] cycle_from;
        logic [4:0] cycle_to;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_ROOT,
        S_LOAD,
        S_SCAN,
        S_POP
    } t_state;

endpackage

// File: hdl/locd_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module locd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lock_order_cycle_detector_top.sv
// top level: lock order tracking with depth-first cycle search
// release, non-recording acquire and halted words finish in idle, result next cycle
// an acquire that reads the order matrix goes through the edge check state; a new edge starts a search
// the search scans one matrix bit per cycle plus a row reload per node visit and per pop;
// input words are taken one at a time, none while a search runs
// synchronous active-low reset clears state, stack count, halt, row valid bits and output valid; no clearing pass
`timescale 1ns / 1ps
module lock_order_cycle_detector_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  locd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output locd_pkg::t_out_word o_out_word
);

    localparam int L = locd_pkg::LOCKS;

    locd_pkg::t_state r_state, n_state;

    logic [locd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_halt, n_halt;
    logic [locd_pkg::LK_W-1:0]  r_hstk [locd_pkg::STACK_DEPTH];
    logic                       hs_we;
    logic [locd_pkg::HS_W-1:0]  hs_waddr;
    logic [locd_pkg::LK_W-1:0]  hs_wdata;
    logic [locd_pkg::LK_W-1:0]  r_lock, n_lock;
    logic [L-1:0]               r_rowv, n_rowv;
    logic [L-1:0]               r_seen, n_seen;
    logic [L-1:0]               r_done, n_done;
    logic [locd_pkg::NXT_W-1:0] r_root, n_root;
    logic [locd_pkg::LK_W-1:0]  r_here, n_here;
    logic [locd_pkg::NXT_W-1:0] r_nxt, n_nxt;
    logic [locd_pkg::SP_W-1:0]  r_sp, n_sp;
    logic [L-1:0]               r_row, n_row;
    logic [locd_pkg::LK_W-1:0]  r_maddr, n_maddr;
    logic                       r_ovalid, n_ovalid;
    locd_pkg::t_out_word        r_out, n_out;

    logic                       m_we, m_re;
    logic [locd_pkg::LK_W-1:0]  m_waddr, m_raddr;
    logic [L-1:0]               m_wdata, m_rdata, mrow;
    logic                       s_we, s_re;
    logic [locd_pkg::SP_W-1:0]  s_waddr, s_raddr;
    logic [locd_pkg::SS_W-1:0]  s_wdata, s_rdata;

    logic                       acc;
    logic [locd_pkg::HS_W-1:0]  top_idx;
    logic [locd_pkg::LK_W-1:0]  top_lock;
    logic [locd_pkg::LK_W-1:0]  tgt;
    logic                       slot_free;

    locd_ram #(.WIDTH(L), .DEPTH(L)) u_matrix (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_re   (m_re),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    locd_ram #(.WIDTH(locd_pkg::SS_W), .DEPTH(L)) u_path (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_re   (s_re),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    assign slot_free   = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == locd_pkg::S_IDLE) && slot_free;
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    assign top_idx  = locd_pkg::HS_W'(r_cnt - locd_pkg::CNT_W'(1));
    assign top_lock = r_hstk[top_idx];
    assign mrow     = r_rowv[r_maddr] ? m_rdata : '0;
    assign tgt      = r_nxt[locd_pkg::LK_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            locd_pkg::S_IDLE: begin
                if (acc && !r_halt && i_in_word.command == locd_pkg::CMD_ACQUIRE
                    && r_cnt < locd_pkg::CNT_W'(locd_pkg::STACK_DEPTH)
                    && r_cnt != '0 && top_lock != i_in_word.lock_number) begin
                    n_state = locd_pkg::S_EDGE;
                end
            end
            locd_pkg::S_EDGE: begin
                n_state = mrow[r_lock] ? locd_pkg::S_IDLE : locd_pkg::S_ROOT;
            end
            locd_pkg::S_ROOT: begin
                if (r_root == locd_pkg::NXT_W'(L)) begin
                    n_state = locd_pkg::S_IDLE;
                end else if (!r_seen[r_root[locd_pkg::LK_W-1:0]]) begin
                    n_state = locd_pkg::S_LOAD;
                end
            end
            locd_pkg::S_LOAD: begin
                n_state = locd_pkg::S_SCAN;
            end
            locd_pkg::S_SCAN: begin
                if (r_nxt == locd_pkg::NXT_W'(L)) begin
                    n_state = (r_sp == '0) ? locd_pkg::S_ROOT : locd_pkg::S_POP;
                end else if (r_row[tgt]) begin
                    if (!r_seen[tgt]) begin
                        n_state = locd_pkg::S_LOAD;
                    end else if (!r_done[tgt]) begin
                        n_state = locd_pkg::S_IDLE;
                    end
                end
            end
            locd_pkg::S_POP: begin
                n_state = locd_pkg::S_LOAD;
            end
            default: n_state = locd_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cnt    = r_cnt;
        n_halt   = r_halt;
        n_lock   = r_lock;
        n_rowv   = r_rowv;
        n_seen   = r_seen;
        n_done   = r_done;
        n_root   = r_root;
        n_here   = r_here;
        n_nxt    = r_nxt;
        n_sp     = r_sp;
        n_row    = r_row;
        n_maddr  = r_maddr;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        hs_we    = 1'b0;
        hs_waddr = r_cnt[locd_pkg::HS_W-1:0];
        hs_wdata = r_lock;
        m_we     = 1'b0;
        m_waddr  = r_maddr;
        m_wdata  = mrow | (L'(1) << r_lock);
        m_re     = 1'b0;
        m_raddr  = r_here;
        s_we     = 1'b0;
        s_waddr  = r_sp;
        s_wdata  = {r_here, locd_pkg::NXT_W'(r_nxt + locd_pkg::NXT_W'(1))};
        s_re     = 1'b0;
        s_raddr  = locd_pkg::SP_W'(r_sp - locd_pkg::SP_W'(1));
        unique case (r_state)
            locd_pkg::S_IDLE: begin
                if (acc) begin
                    n_lock   = i_in_word.lock_number;
                    n_ovalid = 1'b1;
                    n_out    = '0;
                    if (r_halt) begin
                        n_out.status = locd_pkg::ST_HALTED;
                    end else if (i_in_word.command == locd_pkg::CMD_ACQUIRE) begin
                        if (r_cnt >= locd_pkg::CNT_W'(locd_pkg::STACK_DEPTH)) begin
                            n_out.status = locd_pkg::ST_FULL;
                            n_halt       = 1'b1;
                        end else if (r_cnt == '0 || top_lock == i_in_word.lock_number) begin
                            hs_we    = 1'b1;
                            hs_wdata = i_in_word.lock_number;
                            n_cnt    = locd_pkg::CNT_W'(r_cnt + locd_pkg::CNT_W'(1));
                        end else begin
                            // matrix lookup of the top row first
                            n_ovalid = r_ovalid && !i_out_ready;
                            n_out    = r_out;
                            m_re     = 1'b1;
                            m_raddr  = top_lock;
                            n_maddr  = top_lock;
                        end
                    end else if (r_cnt == '0) begin
                        n_out.status = locd_pkg::ST_REL_EMPTY;
                        n_halt       = 1'b1;
                    end else if (top_lock != i_in_word.lock_number) begin
                        n_out.status = locd_pkg::ST_REL_NOTOP;
                        n_halt       = 1'b1;
                    end else begin
                        n_cnt = locd_pkg::CNT_W'(r_cnt - locd_pkg::CNT_W'(1));
                    end
                end
            end
            locd_pkg::S_EDGE: begin
                if (mrow[r_lock]) begin
                    hs_we    = 1'b1;
                    n_cnt    = locd_pkg::CNT_W'(r_cnt + locd_pkg::CNT_W'(1));
                    n_ovalid = 1'b1;
                    n_out    = '0;
                end else begin
                    m_we            = 1'b1;
                    n_rowv[r_maddr] = 1'b1;
                    n_seen          = '0;
                    n_done          = '0;
                    n_root          = '0;
                end
            end
            locd_pkg::S_ROOT: begin
                if (r_root == locd_pkg::NXT_W'(L)) begin
                    hs_we          = 1'b1;
                    n_cnt          = locd_pkg::CNT_W'(r_cnt + locd_pkg::CNT_W'(1));
                    n_ovalid       = 1'b1;
                    n_out          = '0;
                    n_out.new_edge = 1'b1;
                end else if (r_seen[r_root[locd_pkg::LK_W-1:0]]) begin
                    n_root = locd_pkg::NXT_W'(r_root + locd_pkg::NXT_W'(1));
                end else begin
                    n_seen[r_root[locd_pkg::LK_W-1:0]] = 1'b1;
                    n_here  = r_root[locd_pkg::LK_W-1:0];
                    n_nxt   = '0;
                    n_sp    = '0;
                    m_re    = 1'b1;
                    m_raddr = r_root[locd_pkg::LK_W-1:0];
                    n_maddr = r_root[locd_pkg::LK_W-1:0];
                end
            end
            locd_pkg::S_LOAD: begin
                n_row = mrow;
            end
            locd_pkg::S_SCAN: begin
                if (r_nxt == locd_pkg::NXT_W'(L)) begin
                    n_done[r_here] = 1'b1;
                    if (r_sp == '0) begin
                        n_root = locd_pkg::NXT_W'(r_root + locd_pkg::NXT_W'(1));
                    end else begin
                        s_re = 1'b1;
                        n_sp = locd_pkg::SP_W'(r_sp - locd_pkg::SP_W'(1));
                    end
                end else begin
                    n_nxt = locd_pkg::NXT_W'(r_nxt + locd_pkg::NXT_W'(1));
                    if (r_row[tgt]) begin
                        if (!r_seen[tgt]) begin
                            // descend: park the parent and its resume index
                            s_we        = 1'b1;
                            n_sp        = locd_pkg::SP_W'(r_sp + locd_pkg::SP_W'(1));
                            n_seen[tgt] = 1'b1;
                            n_here      = tgt;
                            n_nxt       = '0;
                            m_re        = 1'b1;
                            m_raddr     = tgt;
                            n_maddr     = tgt;
                        end else if (!r_done[tgt]) begin
                            // open node on the path: back edge
                            n_halt           = 1'b1;
                            n_ovalid         = 1'b1;
                            n_out.status     = locd_pkg::ST_CYCLE;
                            n_out.new_edge   = 1'b1;
                            n_out.cycle_from = r_here;
                            n_out.cycle_to   = tgt;
                        end
                    end
                end
            end
            locd_pkg::S_POP: begin
                n_here  = s_rdata[locd_pkg::SS_W-1:locd_pkg::NXT_W];
                n_nxt   = s_rdata[locd_pkg::NXT_W-1:0];
                m_re    = 1'b1;
                m_raddr = s_rdata[locd_pkg::SS_W-1:locd_pkg::NXT_W];
                n_maddr = s_rdata[locd_pkg::SS_W-1:locd_pkg::NXT_W];
            end
            default: begin
                n_ovalid = r_ovalid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= locd_pkg::S_IDLE;
            r_cnt    <= '0;
            r_halt   <= 1'b0;
            r_rowv   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_halt   <= n_halt;
            r_rowv   <= n_rowv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hs_we) begin
            r_hstk[hs_waddr] <= hs_wdata;
        end
        r_lock  <= n_lock;
        r_seen  <= n_seen;
        r_done  <= n_done;
        r_root  <= n_root;
        r_here  <= n_here;
        r_nxt   <= n_nxt;
        r_sp    <= n_sp;
        r_row   <= n_row;
        r_maddr <= n_maddr;
        r_out   <= n_out;
    end

    ap_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != locd_pkg::S_IDLE |-> !o_in_ready)
        else $error("ready while searching");

    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= locd_pkg::CNT_W'(locd_pkg::STACK_DEPTH))
        else $error("held stack count overflow");

    ap_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared without reset");

    ap_done_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == locd_pkg::S_SCAN |-> (r_done & ~r_seen) == '0)
        else $error("finished node never visited");

endmodule
